@@ src/assert_macros.svh @@
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sapq_pkg.sv @@
package sapq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int FILL_W = 4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic    capture;
    logic    exec;
    logic    do_insert;
    logic    do_remove;
    status_t status;
  } sapq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_remove;
    logic full;
    logic empty;
  } sapq_stat_t;

endpackage

@@ src/sapq_if.sv @@
interface sapq_in_if import sapq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [PRIO_W-1:0] item_priority;
  logic [TAG_W-1:0]  item_tag;

  modport source(output valid, func, item_priority, item_tag, input ready);
  modport sink(input valid, func, item_priority, item_tag, output ready);
endinterface

interface sapq_out_if import sapq_pkg::*;;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [TAG_W-1:0]  removed_tag;
  logic [PRIO_W-1:0] removed_priority;
  logic [FILL_W-1:0] fill_count;

  modport source(output valid, status, removed_tag, removed_priority, fill_count,
                 input ready);
  modport sink(input valid, status, removed_tag, removed_priority, fill_count,
               output ready);
endinterface

@@ src/sapq_ctrl.sv @@
module sapq_ctrl import sapq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sapq_stat_t stat,
  output sapq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_WAIT = 2'b01,
    S_WORK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_WAIT);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.status    = ST_DONE;
    case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WORK;
        end
      end
      S_WORK: begin
        // The entry row only moves once the result register can take the word.
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_WAIT;
          if (stat.op_remove) begin
            cmd.do_remove = !stat.empty;
            cmd.status    = stat.empty ? ST_EMPTY : ST_DONE;
          end else begin
            cmd.do_insert = !stat.full;
            cmd.status    = stat.full ? ST_FULL : ST_DONE;
          end
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/sapq_datapath.sv @@
module sapq_datapath import sapq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_func,
  input  logic [PRIO_W-1:0] in_item_priority,
  input  logic [TAG_W-1:0]  in_item_tag,
  input  sapq_cmd_t         cmd,
  output sapq_stat_t        stat,
  output status_t           out_status,
  output logic [TAG_W-1:0]  out_removed_tag,
  output logic [PRIO_W-1:0] out_removed_priority,
  output logic [FILL_W-1:0] out_fill_count
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic              func_r;
  logic [PRIO_W-1:0] prio_in_r;
  logic [TAG_W-1:0]  tag_in_r;

  logic [PRIO_W-1:0] prio_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]  tag_r  [QUEUE_DEPTH];
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  logic [QUEUE_DEPTH-1:0] le;

  status_t            status_r;
  logic [TAG_W-1:0]   rtag_r;
  logic [PRIO_W-1:0]  rprio_r;
  logic [FILL_W-1:0]  fill_r;
  logic [CntW+FILL_W-1:0] fill_ext;

  assign stat.op_remove = (func_r == FUNC_REMOVE);
  assign stat.full      = (cnt_r == CntW'(QUEUE_DEPTH));
  assign stat.empty     = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.do_insert) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.do_remove) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= in_func;
      prio_in_r <= in_item_priority;
      tag_in_r  <= in_item_tag;
    end
  end

  // Each occupied entry flags whether it stays ahead of the new word. The
  // array is sorted, so the flags form a run from the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PRIO_W-1:0] ins_prio, rem_prio;
    logic [TAG_W-1:0]  ins_tag, rem_tag;

    assign le[i] = (CntW'(i) < cnt_r) && (prio_r[i] <= prio_in_r);

    if (i == 0) begin : g_head
      assign ins_prio = prio_in_r;
      assign ins_tag  = tag_in_r;
    end else begin : g_body
      logic take_new;
      assign take_new = !le[i] && le[i-1];
      assign ins_prio = take_new ? prio_in_r : prio_r[i-1];
      assign ins_tag  = take_new ? tag_in_r : tag_r[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rem_prio = prio_r[i];
      assign rem_tag  = tag_r[i];
    end else begin : g_mid
      assign rem_prio = prio_r[i+1];
      assign rem_tag  = tag_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert && !le[i]) begin
        prio_r[i] <= ins_prio;
        tag_r[i]  <= ins_tag;
      end else if (cmd.do_remove) begin
        prio_r[i] <= rem_prio;
        tag_r[i]  <= rem_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= cmd.status;
      rtag_r   <= cmd.do_remove ? tag_r[0] : '0;
      rprio_r  <= cmd.do_remove ? prio_r[0] : '0;
      fill_r   <= fill_ext[FILL_W-1:0];
    end
  end

  assign out_status           = status_r;
  assign out_removed_tag      = rtag_r;
  assign out_removed_priority = rprio_r;
  assign out_fill_count       = fill_r;

endmodule

@@ src/sorted_array_priority_queue_core.sv @@
// Bounded priority queue of QUEUE_DEPTH entries kept as a sorted row of
// registers. An insert word places its priority and tag behind every entry of
// lower or equal priority; a remove word returns the head entry, which has the
// smallest priority and is the oldest among equals. Every word gives one result
// word with a status and the fill count (low four bits). A word is first
// captured, then every entry compares against the new priority and shifts in
// parallel; the block takes no new word until that step is done. The result
// register holds a finished word while the next one is captured; the
// compare-and-shift step waits while that register is full and not yet taken,
// so a stalled result sink holds up the block.
module sorted_array_priority_queue_core import sapq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  sapq_in_if.sink     in_ch,
  sapq_out_if.source  out_ch
);

  sapq_cmd_t  cmd;
  sapq_stat_t stat;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sapq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_func              (in_ch.func),
    .in_item_priority     (in_ch.item_priority),
    .in_item_tag          (in_ch.item_tag),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_status           (out_ch.status),
    .out_removed_tag      (out_ch.removed_tag),
    .out_removed_priority (out_ch.removed_priority),
    .out_fill_count       (out_ch.fill_count)
  );

endmodule

@@ src/sapq_checker.sv @@
`include "assert_macros.svh"

module sapq_checker import sapq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input status_t           out_status,
  input logic [TAG_W-1:0]  out_removed_tag,
  input logic [PRIO_W-1:0] out_removed_priority,
  input logic [FILL_W-1:0] out_fill_count
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW+FILL_W-1:0] DepthExt = (CntW + FILL_W)'(QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] FullFill = DepthExt[FILL_W-1:0];

  logic out_stall;
  assign out_stall = out_valid && !out_ready;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_status) && $stable(out_removed_tag) && $stable(out_removed_priority) && $stable(out_fill_count), "result word changed while stalled")

  // Only one word is in work at a time.
  `ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while a word is in work")

  `ASSERT_SAME(a_full_count, clk, rst_n, out_valid && out_status == ST_FULL, out_fill_count == FullFill, "full status with wrong fill count")

  `ASSERT_SAME(a_empty_count, clk, rst_n, out_valid && out_status == ST_EMPTY, out_fill_count == '0, "empty status with nonzero fill count")

  `ASSERT_SAME(a_idle_fields, clk, rst_n, out_valid && out_status != ST_DONE, out_removed_tag == '0 && out_removed_priority == '0, "ignored word reports a removed entry")

endmodule

bind sorted_array_priority_queue_core sapq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sapq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_removed_tag      (out_ch.removed_tag),
  .out_removed_priority (out_ch.removed_priority),
  .out_fill_count       (out_ch.fill_count)
);
